// ===== hw/rtl/mwe_pkg.sv =====
// Shared types and constants for the Microwire EEPROM master.
package mwe_pkg;

    // Item kinds.
    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_READ_ALL   = 3'd1;
    localparam logic [2:0] KIND_WRITE_EN   = 3'd2;
    localparam logic [2:0] KIND_WRITE_WORD = 3'd3;
    localparam logic [2:0] KIND_WRITE_DIS  = 3'd4;

    // Completion status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DEVICE = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT   = 2'd2;
    localparam logic [1:0] STATUS_REFUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WORD_COUNT   = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_PROGRAM_WAIT = 2'd2;
    localparam logic [1:0] CFG_READY_LEVEL  = 2'd3;

    // 11-bit Microwire command codes (start bit, opcode, address field).
    localparam logic [10:0] CMD_READ_ALL = 11'h600;
    localparam logic [10:0] CMD_EWEN     = 11'h4C0;
    localparam logic [10:0] CMD_EWDS     = 11'h400;
    localparam logic [10:0] CMD_ERASE    = 11'h700;
    localparam logic [10:0] CMD_WRITE    = 11'h500;

    localparam int SHIFT_W = 27;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  word_address;
        logic [15:0] write_value;
        logic        data_out_pin;
    } item_t;

    typedef struct packed {
        logic [7:0]  word_count;
        logic [7:0]  half_period_ticks;
        logic [23:0] program_wait_ticks;
        logic        ready_level;
    } cfg_t;

    typedef struct packed {
        logic        chip_select;
        logic        serial_clock;
        logic        data_in_pin;
        logic [15:0] read_data;
        logic [6:0]  read_address;
        logic        read_valid;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== hw/rtl/mwe_seq.sv =====
// Serial command sequencer: holds the bus state and computes one step per item.
module mwe_seq #(
    parameter int MAX_WORDS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  mwe_pkg::item_t    item,
    input  mwe_pkg::cfg_t     cfg,
    output mwe_pkg::result_t  result
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RA_LO   = 4'd1;
    localparam logic [3:0] ST_RA_HI   = 4'd2;
    localparam logic [3:0] ST_SH_LO   = 4'd3;
    localparam logic [3:0] ST_SH_HI   = 4'd4;
    localparam logic [3:0] ST_ER_LO   = 4'd5;
    localparam logic [3:0] ST_ER_HI   = 4'd6;
    localparam logic [3:0] ST_ER_WAIT = 4'd7;
    localparam logic [3:0] ST_PR_PRE  = 4'd8;
    localparam logic [3:0] ST_PR_LO   = 4'd9;
    localparam logic [3:0] ST_PR_HI   = 4'd10;
    localparam logic [3:0] ST_PR_WAIT = 4'd11;
    localparam logic [3:0] ST_DM_LO   = 4'd12;
    localparam logic [3:0] ST_DM_HI   = 4'd13;
    localparam logic [3:0] ST_RD_LO   = 4'd14;
    localparam logic [3:0] ST_RD_HI   = 4'd15;

    localparam logic [8:0] MaxWords = 9'(MAX_WORDS);
    localparam logic [4:0] CmdTopBit = 5'(mwe_pkg::SHIFT_W - 1);
    localparam logic [4:0] DataBits = 5'd16;

    logic [3:0]                     state_reg, state_next;
    logic [mwe_pkg::SHIFT_W-1:0]    shift_reg, shift_next;
    logic [4:0]                     bit_cnt_reg, bit_cnt_next;
    logic [7:0]                     word_idx_reg, word_idx_next;
    logic [23:0]                    wait_cnt_reg, wait_cnt_next;
    logic [7:0]                     half_cnt_reg, half_cnt_next;
    logic [1:0]                     err_reg, err_next;
    logic [6:0]                     pend_addr_reg, pend_addr_next;

    logic        is_cmd;
    logic        cmd_accept;
    logic [7:0]  half_period;
    logic [7:0]  half_inc;
    logic        phase_end;
    logic [23:0] wait_load;
    logic [23:0] wait_dec;
    logic [4:0]  bit_dec;
    logic [8:0]  word_limit;
    logic [8:0]  word_idx_inc;
    logic        done;
    logic        rvalid;
    logic [3:0]  drv_state;
    logic [mwe_pkg::SHIFT_W-1:0] drv_shift;
    logic [4:0]  drv_bit_cnt;
    logic [7:0]  drv_half_cnt;
    logic        drv_bit;
    logic        cs, sk, di;

    assign is_cmd = (item.kind == mwe_pkg::KIND_READ_ALL) ||
                    (item.kind == mwe_pkg::KIND_WRITE_EN) ||
                    (item.kind == mwe_pkg::KIND_WRITE_WORD) ||
                    (item.kind == mwe_pkg::KIND_WRITE_DIS);
    assign cmd_accept = is_cmd && (state_reg == ST_IDLE);

    assign half_period = (cfg.half_period_ticks != 8'd0) ? cfg.half_period_ticks : 8'd1;
    assign half_inc    = half_cnt_reg + 8'd1;
    assign phase_end   = (half_inc >= half_period);
    assign wait_load   = (cfg.program_wait_ticks != 24'd0) ? cfg.program_wait_ticks : 24'd1;
    assign wait_dec    = wait_cnt_reg - 24'd1;
    assign bit_dec     = bit_cnt_reg - 5'd1;
    assign word_limit  = ({1'b0, cfg.word_count} < MaxWords) ? {1'b0, cfg.word_count} : MaxWords;
    assign word_idx_inc = {1'b0, word_idx_reg} + 9'd1;

    always_comb begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        word_idx_next  = word_idx_reg;
        wait_cnt_next  = wait_cnt_reg;
        half_cnt_next  = half_cnt_reg;
        err_next       = err_reg;
        pend_addr_next = pend_addr_reg;
        done           = 1'b0;
        rvalid         = 1'b0;

        if (is_cmd) begin
            if (cmd_accept) begin
                half_cnt_next = '0;
                err_next      = mwe_pkg::STATUS_OK;
                word_idx_next = '0;
                wait_cnt_next = '0;
                bit_cnt_next  = CmdTopBit;
                unique case (item.kind)
                    mwe_pkg::KIND_READ_ALL: begin
                        shift_next = {mwe_pkg::CMD_READ_ALL, 16'h0000};
                        state_next = ST_RA_LO;
                    end
                    mwe_pkg::KIND_WRITE_EN: begin
                        shift_next = {mwe_pkg::CMD_EWEN, 16'h0000};
                        state_next = ST_SH_LO;
                    end
                    mwe_pkg::KIND_WRITE_DIS: begin
                        shift_next = {mwe_pkg::CMD_EWDS, 16'h0000};
                        state_next = ST_SH_LO;
                    end
                    default: begin
                        pend_addr_next = item.word_address;
                        shift_next = {mwe_pkg::CMD_ERASE | {4'b0000, item.word_address},
                                      item.write_value};
                        state_next = ST_ER_LO;
                    end
                endcase
            end
        end else begin
            unique case (state_reg)
                ST_RA_LO, ST_SH_LO, ST_ER_LO, ST_PR_LO: begin
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        state_next = state_reg + 4'd1;
                    end
                end
                ST_RA_HI, ST_SH_HI, ST_ER_HI, ST_PR_HI: begin
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        // The program phase also shifts out the data word.
                        if (bit_cnt_reg == ((state_reg == ST_PR_HI) ? 5'd0 : DataBits)) begin
                            unique case (state_reg)
                                ST_RA_HI: state_next = ST_DM_LO;
                                ST_SH_HI: done = 1'b1;
                                ST_ER_HI: state_next = ST_ER_WAIT;
                                default:  state_next = ST_PR_WAIT;
                            endcase
                        end else begin
                            bit_cnt_next = bit_dec;
                            state_next   = state_reg - 4'd1;
                        end
                    end
                end
                ST_ER_WAIT, ST_PR_WAIT: begin
                    // The half counter marks the CS-low tick that opens the wait.
                    if (half_cnt_reg == 8'd0) begin
                        half_cnt_next = 8'd1;
                        wait_cnt_next = wait_load;
                    end else begin
                        wait_cnt_next = wait_dec;
                        if (wait_dec == 24'd0) begin
                            if (item.data_out_pin != cfg.ready_level) begin
                                err_next = mwe_pkg::STATUS_TIMEOUT;
                            end
                            half_cnt_next = 8'd0;
                            if (state_reg == ST_ER_WAIT) begin
                                state_next = ST_PR_PRE;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    end
                end
                ST_PR_PRE: begin
                    shift_next    = {mwe_pkg::CMD_WRITE | {4'b0000, pend_addr_reg},
                                     shift_reg[15:0]};
                    bit_cnt_next  = CmdTopBit;
                    half_cnt_next = 8'd0;
                    state_next    = ST_PR_LO;
                end
                ST_DM_LO: begin
                    if (half_cnt_reg == 8'd0) begin
                        shift_next = {{(mwe_pkg::SHIFT_W-1){1'b0}}, item.data_out_pin};
                    end
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        state_next = ST_DM_HI;
                    end
                end
                ST_DM_HI: begin
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        if (shift_reg[0]) begin
                            err_next = mwe_pkg::STATUS_NO_DEVICE;
                            done     = 1'b1;
                        end else if (word_limit == 9'd0) begin
                            done = 1'b1;
                        end else begin
                            bit_cnt_next  = DataBits;
                            word_idx_next = '0;
                            shift_next    = '0;
                            state_next    = ST_RD_LO;
                        end
                    end
                end
                ST_RD_LO: begin
                    if (half_cnt_reg == 8'd0) begin
                        shift_next = {shift_reg[mwe_pkg::SHIFT_W-2:0], item.data_out_pin};
                    end
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        state_next = ST_RD_HI;
                    end
                end
                ST_RD_HI: begin
                    half_cnt_next = phase_end ? 8'd0 : half_inc;
                    if (phase_end) begin
                        bit_cnt_next = bit_dec;
                        state_next   = ST_RD_LO;
                        if (bit_dec == 5'd0) begin
                            rvalid = 1'b1;
                            if (word_idx_inc >= word_limit) begin
                                done = 1'b1;
                            end else begin
                                word_idx_next = word_idx_inc[7:0];
                                bit_cnt_next  = DataBits;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            if (done) begin
                state_next    = ST_IDLE;
                half_cnt_next = 8'd0;
            end
        end
    end

    // A command shows the levels of the step it set up; a tick shows its own.
    assign drv_state    = cmd_accept ? state_next : state_reg;
    assign drv_shift    = cmd_accept ? shift_next : shift_reg;
    assign drv_bit_cnt  = cmd_accept ? bit_cnt_next : bit_cnt_reg;
    assign drv_half_cnt = cmd_accept ? half_cnt_next : half_cnt_reg;
    assign drv_bit = (drv_bit_cnt < 5'(mwe_pkg::SHIFT_W)) ? drv_shift[drv_bit_cnt] : 1'b0;

    always_comb begin
        cs = 1'b0;
        sk = 1'b0;
        di = 1'b0;
        unique case (drv_state)
            ST_RA_LO, ST_SH_LO, ST_ER_LO, ST_PR_LO: begin
                cs = 1'b1;
                di = drv_bit;
            end
            ST_RA_HI, ST_SH_HI, ST_ER_HI, ST_PR_HI: begin
                cs = 1'b1;
                sk = 1'b1;
                di = drv_bit;
            end
            ST_ER_WAIT, ST_PR_WAIT: begin
                cs = (drv_half_cnt != 8'd0);
            end
            ST_DM_LO, ST_RD_LO: begin
                cs = 1'b1;
            end
            ST_DM_HI, ST_RD_HI: begin
                cs = 1'b1;
                sk = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.chip_select  = cs;
        result.serial_clock = sk;
        result.data_in_pin  = di;
        result.read_data    = rvalid ? shift_reg[15:0] : 16'h0000;
        result.read_address = rvalid ? word_idx_reg[6:0] : 7'd0;
        result.read_valid   = rvalid;
        result.busy_res     = (state_next != ST_IDLE);
        result.done_res     = done;
        if (is_cmd && !cmd_accept) begin
            result.status = mwe_pkg::STATUS_REFUSED;
        end else if (done) begin
            result.status = err_next;
        end else begin
            result.status = mwe_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            shift_reg     <= '0;
            bit_cnt_reg   <= '0;
            word_idx_reg  <= '0;
            wait_cnt_reg  <= '0;
            half_cnt_reg  <= '0;
            err_reg       <= '0;
            pend_addr_reg <= '0;
        end else if (step_en) begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            bit_cnt_reg   <= bit_cnt_next;
            word_idx_reg  <= word_idx_next;
            wait_cnt_reg  <= wait_cnt_next;
            half_cnt_reg  <= half_cnt_next;
            err_reg       <= err_next;
            pend_addr_reg <= pend_addr_next;
        end
    end

endmodule

// ===== hw/rtl/microwire_eeprom_master.sv =====
// Top level of the Microwire EEPROM master: input and result registers, config registers.
//
//   Channel   Direction  Handshake              Carries
//   s_        in         s_valid / s_ready      one command or tick item
//   m_        out        m_valid / m_ready      one result item per input item
//   cfg_      in         cfg_wr_en              register index and write data
//
// An accepted item waits in the input register; the sequencer step between it and the output
// register is combinational; its result is registered as the item leaves the input register.
// One item per cycle is taken while results are taken.
// The sequencer state advances only when an item leaves the input register.
// A stalled result holds the output register and, behind it, the input register.
// Reset is synchronous and active low; all config registers return to their defaults.
module microwire_eeprom_master #(
    parameter int MAX_WORDS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [6:0]  s_word_address,
    input  logic [15:0] s_write_value,
    input  logic        s_data_out_pin,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_chip_select,
    output logic        m_serial_clock,
    output logic        m_data_in_pin,
    output logic [15:0] m_read_data,
    output logic [6:0]  m_read_address,
    output logic        m_read_valid,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [1:0]  m_status,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wr_data
);

    logic              in_vld_reg;
    mwe_pkg::item_t    item_reg;
    logic              m_vld_reg;
    mwe_pkg::result_t  result_reg;
    mwe_pkg::result_t  step_result;
    mwe_pkg::cfg_t     cfg_reg;
    logic              fire;

    assign fire    = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.kind         <= s_kind;
            item_reg.word_address <= s_word_address;
            item_reg.write_value  <= s_write_value;
            item_reg.data_out_pin <= s_data_out_pin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.word_count         <= 8'd128;
            cfg_reg.half_period_ticks  <= 8'd1;
            cfg_reg.program_wait_ticks <= 24'd10000;
            cfg_reg.ready_level        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mwe_pkg::CFG_WORD_COUNT:   cfg_reg.word_count <= cfg_wr_data[7:0];
                mwe_pkg::CFG_HALF_PERIOD:  cfg_reg.half_period_ticks <= cfg_wr_data[7:0];
                mwe_pkg::CFG_PROGRAM_WAIT: cfg_reg.program_wait_ticks <= cfg_wr_data;
                default:                   cfg_reg.ready_level <= cfg_wr_data[0];
            endcase
        end
    end

    mwe_seq #(
        .MAX_WORDS (MAX_WORDS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (!m_vld_reg || m_ready) begin
            m_vld_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= step_result;
        end
    end

    assign m_valid        = m_vld_reg;
    assign m_chip_select  = result_reg.chip_select;
    assign m_serial_clock = result_reg.serial_clock;
    assign m_data_in_pin  = result_reg.data_in_pin;
    assign m_read_data    = result_reg.read_data;
    assign m_read_address = result_reg.read_address;
    assign m_read_valid   = result_reg.read_valid;
    assign m_busy_res     = result_reg.busy_res;
    assign m_done_res     = result_reg.done_res;
    assign m_status       = result_reg.status;

`ifndef ASSERT_OFF
    // A finished sequence never reports itself as still running.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && result_reg.done_res) |-> !result_reg.busy_res)
        else $error("done and busy reported together");

    // A refused command only happens while a sequence is running, and ends nothing.
    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && result_reg.status == mwe_pkg::STATUS_REFUSED)
            |-> (result_reg.busy_res && !result_reg.done_res))
        else $error("refusal outside of a running sequence");

    // A completed word belongs to a sequence that is running or ends right there.
    a_word_in_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && result_reg.read_valid)
            |-> (result_reg.busy_res || result_reg.done_res))
        else $error("read word outside of a sequence");

    // The serial clock only toggles with the chip selected.
    a_sk_needs_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && result_reg.serial_clock) |-> result_reg.chip_select)
        else $error("serial clock high with chip select low");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Microwire EEPROM master with a model of the sequencer.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF_NS     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MODEL_MAX_WORDS = 128;
    localparam int MAX_REPORTS     = 10;
    localparam int PART_ITEMS      = 40;

    // Kinds above the defined commands behave as plain ticks.
    localparam logic [2:0] KIND_ALIAS_LO = 3'd5;
    localparam logic [2:0] KIND_ALIAS_HI = 3'd7;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RA_LO   = 4'd1;
    localparam logic [3:0] S_RA_HI   = 4'd2;
    localparam logic [3:0] S_SH_LO   = 4'd3;
    localparam logic [3:0] S_SH_HI   = 4'd4;
    localparam logic [3:0] S_ER_LO   = 4'd5;
    localparam logic [3:0] S_ER_HI   = 4'd6;
    localparam logic [3:0] S_ER_WAIT = 4'd7;
    localparam logic [3:0] S_PR_PRE  = 4'd8;
    localparam logic [3:0] S_PR_LO   = 4'd9;
    localparam logic [3:0] S_PR_HI   = 4'd10;
    localparam logic [3:0] S_PR_WAIT = 4'd11;
    localparam logic [3:0] S_DM_LO   = 4'd12;
    localparam logic [3:0] S_DM_HI   = 4'd13;
    localparam logic [3:0] S_RD_LO   = 4'd14;
    localparam logic [3:0] S_RD_HI   = 4'd15;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_kind         = mwe_pkg::KIND_TICK;
    logic [6:0]  s_word_address = '0;
    logic [15:0] s_write_value  = '0;
    logic        s_data_out_pin = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_chip_select;
    logic        m_serial_clock;
    logic        m_data_in_pin;
    logic [15:0] m_read_data;
    logic [6:0]  m_read_address;
    logic        m_read_valid;
    logic        m_busy_res;
    logic        m_done_res;
    logic [1:0]  m_status;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = mwe_pkg::CFG_WORD_COUNT;
    logic [23:0] cfg_wr_data    = '0;

    microwire_eeprom_master DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_word_address (s_word_address),
        .s_write_value  (s_write_value),
        .s_data_out_pin (s_data_out_pin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chip_select  (m_chip_select),
        .m_serial_clock (m_serial_clock),
        .m_data_in_pin  (m_data_in_pin),
        .m_read_data    (m_read_data),
        .m_read_address (m_read_address),
        .m_read_valid   (m_read_valid),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_status       (m_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    mwe_pkg::item_t   pending_items[$];
    mwe_pkg::result_t expected_results[$];

    int tx_idle_pct     = 32;
    int rx_idle_pct     = 60;
    int hold_at         = 32'h7FFFFFFF;
    int hold_left       = 0;
    bit hold_armed      = 1'b1;
    int accepted_items  = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int items_pushed    = 0;
    int read_all_count  = 0;
    int write_word_count = 0;
    int enable_count    = 0;
    int refused_count   = 0;
    int words_read      = 0;
    int critical_ok_pct = 85;
    int cycle_count     = 0;

    // Model copy of the configuration registers.
    logic [7:0]  cf_words;
    logic [7:0]  cf_half;
    logic [23:0] cf_wait;
    logic        cf_ready;

    // Model copy of the sequencer.
    logic [3:0]  seq_st;
    logic [26:0] tx_shift;
    logic [4:0]  bit_pos;
    logic [7:0]  word_idx;
    logic [23:0] wait_left;
    logic [7:0]  half_cnt;
    logic [1:0]  err_code;
    logic [6:0]  latched_addr;

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    function automatic void model_reset();
        cf_words = 8'd128;
        cf_half = 8'd1;
        cf_wait = 24'd10000;
        cf_ready = 1'b0;
        seq_st = S_IDLE;
        tx_shift = '0;
        bit_pos = '0;
        word_idx = '0;
        wait_left = '0;
        half_cnt = '0;
        err_code = '0;
        latched_addr = '0;
    endfunction

    function automatic bit half_elapsed();
        logic [7:0] span;
        span = (cf_half == 8'd0) ? 8'd1 : cf_half;
        half_cnt = half_cnt + 8'd1;
        if (half_cnt >= span) begin
            half_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void pin_levels(output logic cs, output logic sk, output logic di);
        logic [31:0] wide;
        wide = {5'b0, tx_shift} >> bit_pos;
        cs = 1'b0;
        sk = 1'b0;
        di = 1'b0;
        case (seq_st)
            S_RA_LO, S_SH_LO, S_ER_LO, S_PR_LO: begin
                cs = 1'b1;
                di = wide[0];
            end
            S_RA_HI, S_SH_HI, S_ER_HI, S_PR_HI: begin
                cs = 1'b1;
                sk = 1'b1;
                di = wide[0];
            end
            S_ER_WAIT, S_PR_WAIT: cs = (half_cnt != 8'd0);
            S_DM_LO, S_RD_LO: cs = 1'b1;
            S_DM_HI, S_RD_HI: begin
                cs = 1'b1;
                sk = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic mwe_pkg::result_t predict_result(input mwe_pkg::item_t it);
        mwe_pkg::result_t r;
        logic       cs_l, sk_l, di_l;
        logic       finished;
        logic [7:0] limit;
        logic [3:0] cur;
        r = '0;
        finished = 1'b0;
        cur = seq_st;
        limit = (cf_words < MODEL_MAX_WORDS) ? cf_words : 8'(MODEL_MAX_WORDS);
        if (it.kind >= mwe_pkg::KIND_READ_ALL && it.kind <= mwe_pkg::KIND_WRITE_DIS) begin
            if (cur != S_IDLE) begin
                r.status = mwe_pkg::STATUS_REFUSED;
            end else begin
                half_cnt = '0;
                err_code = mwe_pkg::STATUS_OK;
                word_idx = '0;
                wait_left = '0;
                bit_pos = 5'd26;
                case (it.kind)
                    mwe_pkg::KIND_READ_ALL: begin
                        tx_shift = {mwe_pkg::CMD_READ_ALL, 16'h0000};
                        seq_st = S_RA_LO;
                    end
                    mwe_pkg::KIND_WRITE_EN: begin
                        tx_shift = {mwe_pkg::CMD_EWEN, 16'h0000};
                        seq_st = S_SH_LO;
                    end
                    mwe_pkg::KIND_WRITE_DIS: begin
                        tx_shift = {mwe_pkg::CMD_EWDS, 16'h0000};
                        seq_st = S_SH_LO;
                    end
                    default: begin
                        latched_addr = it.word_address;
                        tx_shift = {mwe_pkg::CMD_ERASE | {4'b0, it.word_address},
                                    it.write_value};
                        seq_st = S_ER_LO;
                    end
                endcase
            end
            pin_levels(cs_l, sk_l, di_l);
        end else begin
            pin_levels(cs_l, sk_l, di_l);
            case (cur)
                S_RA_LO, S_SH_LO, S_ER_LO, S_PR_LO: begin
                    if (half_elapsed()) seq_st = cur + 4'd1;
                end
                S_RA_HI, S_SH_HI, S_ER_HI, S_PR_HI: begin
                    if (half_elapsed()) begin
                        // The program command runs on through its 16 data bits.
                        if (bit_pos == ((cur == S_PR_HI) ? 5'd0 : 5'd16)) begin
                            case (cur)
                                S_RA_HI: seq_st = S_DM_LO;
                                S_SH_HI: finished = 1'b1;
                                S_ER_HI: seq_st = S_ER_WAIT;
                                default: seq_st = S_PR_WAIT;
                            endcase
                        end else begin
                            bit_pos = bit_pos - 5'd1;
                            seq_st = cur - 4'd1;
                        end
                    end
                end
                S_ER_WAIT, S_PR_WAIT: begin
                    if (half_cnt == 8'd0) begin
                        half_cnt = 8'd1;
                        wait_left = (cf_wait == 24'd0) ? 24'd1 : cf_wait;
                    end else begin
                        wait_left = wait_left - 24'd1;
                        if (wait_left == 24'd0) begin
                            if (it.data_out_pin != cf_ready) err_code = mwe_pkg::STATUS_TIMEOUT;
                            half_cnt = '0;
                            if (cur == S_ER_WAIT) seq_st = S_PR_PRE;
                            else finished = 1'b1;
                        end
                    end
                end
                S_PR_PRE: begin
                    tx_shift = {mwe_pkg::CMD_WRITE | {4'b0, latched_addr}, tx_shift[15:0]};
                    bit_pos = 5'd26;
                    half_cnt = '0;
                    seq_st = S_PR_LO;
                end
                S_DM_LO: begin
                    if (half_cnt == 8'd0) tx_shift = {26'b0, it.data_out_pin};
                    if (half_elapsed()) seq_st = S_DM_HI;
                end
                S_DM_HI: begin
                    if (half_elapsed()) begin
                        if (tx_shift[0]) begin
                            err_code = mwe_pkg::STATUS_NO_DEVICE;
                            finished = 1'b1;
                        end else if (limit == 8'd0) begin
                            finished = 1'b1;
                        end else begin
                            bit_pos = 5'd16;
                            word_idx = '0;
                            tx_shift = '0;
                            seq_st = S_RD_LO;
                        end
                    end
                end
                S_RD_LO: begin
                    if (half_cnt == 8'd0) tx_shift = {tx_shift[25:0], it.data_out_pin};
                    if (half_elapsed()) seq_st = S_RD_HI;
                end
                S_RD_HI: begin
                    if (half_elapsed()) begin
                        bit_pos = bit_pos - 5'd1;
                        seq_st = S_RD_LO;
                        if (bit_pos == 5'd0) begin
                            r.read_valid = 1'b1;
                            r.read_data = tx_shift[15:0];
                            r.read_address = word_idx[6:0];
                            if (int'(word_idx) + 1 >= int'(limit)) begin
                                finished = 1'b1;
                            end else begin
                                word_idx = word_idx + 8'd1;
                                bit_pos = 5'd16;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (finished) begin
                seq_st = S_IDLE;
                half_cnt = '0;
                r.done_res = 1'b1;
                r.status = err_code;
            end
        end
        r.chip_select = cs_l;
        r.serial_clock = sk_l;
        r.data_in_pin = di_l;
        r.busy_res = (seq_st != S_IDLE);
        return r;
    endfunction

    // DO level for the next tick: the dummy bit and the end-of-wait sample are
    // steered toward success most of the time, every other bit is random.
    function automatic logic pick_data_out();
        bit good;
        good = ($urandom_range(99) < critical_ok_pct);
        if (seq_st == S_DM_LO && half_cnt == 8'd0) return good ? 1'b0 : 1'b1;
        if ((seq_st == S_ER_WAIT || seq_st == S_PR_WAIT) && half_cnt != 8'd0
                && wait_left == 24'd1)
            return good ? cf_ready : ~cf_ready;
        return 1'($urandom_range(1));
    endfunction

    // Called only away from the rising edge, so the driver never races the queues.
    task automatic push_item(input logic [2:0] kind, input logic [6:0] addr,
                             input logic [15:0] val, input logic din);
        mwe_pkg::item_t   it;
        mwe_pkg::result_t r;
        it.kind = kind;
        it.word_address = addr;
        it.write_value = val;
        it.data_out_pin = din;
        if (seq_st == S_IDLE) begin
            case (kind)
                mwe_pkg::KIND_READ_ALL: read_all_count++;
                mwe_pkg::KIND_WRITE_WORD: write_word_count++;
                mwe_pkg::KIND_WRITE_EN, mwe_pkg::KIND_WRITE_DIS: enable_count++;
                default: ;
            endcase
        end
        r = predict_result(it);
        if (r.status == mwe_pkg::STATUS_REFUSED) refused_count++;
        if (r.read_valid) words_read++;
        pending_items.push_back(it);
        expected_results.push_back(r);
        items_pushed++;
    endtask

    task automatic push_command(input logic [2:0] kind);
        push_item(kind, 7'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic tick_until_idle(input int noise_pct);
        int roll;
        while (seq_st != S_IDLE) begin
            roll = $urandom_range(99);
            if (roll < noise_pct)
                push_command(3'($urandom_range(mwe_pkg::KIND_WRITE_DIS,
                                               mwe_pkg::KIND_READ_ALL)));
            else if (roll < 2 * noise_pct)
                push_item(3'($urandom_range(KIND_ALIAS_HI, KIND_ALIAS_LO)), 7'($urandom),
                          16'($urandom), pick_data_out());
            else
                push_item(mwe_pkg::KIND_TICK, 7'($urandom), 16'($urandom), pick_data_out());
        end
    endtask

    task automatic run_sequence();
        int roll;
        logic [2:0] cmd;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(3, 1))
                push_item($urandom_range(1) ? mwe_pkg::KIND_TICK : KIND_ALIAS_LO,
                          7'($urandom), 16'($urandom), 1'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 35) cmd = mwe_pkg::KIND_READ_ALL;
        else if (roll < 70) cmd = mwe_pkg::KIND_WRITE_WORD;
        else if (roll < 85) cmd = mwe_pkg::KIND_WRITE_EN;
        else cmd = mwe_pkg::KIND_WRITE_DIS;
        push_command(cmd);
        tick_until_idle(2);
    endtask

    task automatic fill_random(input int count);
        int start;
        @(negedge aclk);
        start = items_pushed;
        while (items_pushed - start < count) run_sequence();
    endtask

    task automatic wait_all_done();
        @(negedge aclk);
        while (pending_items.size() != 0 || expected_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mwe_pkg::CFG_WORD_COUNT:   cf_words = data[7:0];
            mwe_pkg::CFG_HALF_PERIOD:  cf_half = data[7:0];
            mwe_pkg::CFG_PROGRAM_WAIT: cf_wait = data;
            default:                   cf_ready = data[0];
        endcase
    endtask

    // Unused upper bits of the write data are randomized; the block must drop them.
    task automatic set_config(input logic [7:0] words, input logic [7:0] half,
                              input logic [23:0] wait_ticks, input logic ready);
        write_reg(mwe_pkg::CFG_WORD_COUNT, {16'($urandom), words});
        write_reg(mwe_pkg::CFG_HALF_PERIOD, {16'($urandom), half});
        write_reg(mwe_pkg::CFG_PROGRAM_WAIT, wait_ticks);
        write_reg(mwe_pkg::CFG_READY_LEVEL, {23'($urandom), ready});
    endtask

    always @(posedge aclk) begin : driver
        mwe_pkg::item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) accepted_items <= accepted_items + 1;
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= next_item.kind;
                    s_word_address <= next_item.word_address;
                    s_write_value <= next_item.write_value;
                    s_data_out_pin <= next_item.data_out_pin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver stall, so the block fills and pushes back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && accepted_items >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        mwe_pkg::result_t seen;
        mwe_pkg::result_t want;
        bit      wrong;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen.chip_select = m_chip_select;
                seen.serial_clock = m_serial_clock;
                seen.data_in_pin = m_data_in_pin;
                seen.read_data = m_read_data;
                seen.read_address = m_read_address;
                seen.read_valid = m_read_valid;
                seen.busy_res = m_busy_res;
                seen.done_res = m_done_res;
                seen.status = m_status;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("Result %0d arrived with nothing predicted", results_checked);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    wrong = (seen.chip_select !== want.chip_select)
                          || (seen.serial_clock !== want.serial_clock)
                          || (seen.data_in_pin !== want.data_in_pin)
                          || (seen.read_data !== want.read_data)
                          || (seen.read_address !== want.read_address)
                          || (seen.read_valid !== want.read_valid)
                          || (seen.busy_res !== want.busy_res)
                          || (seen.done_res !== want.done_res)
                          || (seen.status !== want.status);
                    if (wrong) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("Result %0d expected cs=%b sk=%b di=%b data=%h addr=%0d",
                                     results_checked, want.chip_select, want.serial_clock,
                                     want.data_in_pin, want.read_data, want.read_address);
                            $display("    rv=%b busy=%b done=%b status=%0d; got cs=%b sk=%b di=%b",
                                     want.read_valid, want.busy_res, want.done_res, want.status,
                                     seen.chip_select, seen.serial_clock, seen.data_in_pin);
                            $display("    data=%h addr=%0d rv=%b busy=%b done=%b status=%0d",
                                     seen.read_data, seen.read_address, seen.read_valid,
                                     seen.busy_res, seen.done_res, seen.status);
                        end
                        mismatch_count++;
                    end
                end
                results_checked++;
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int fail_total;
        model_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle ticks of every kind, a bare command and refusals while busy.
        @(negedge aclk);
        critical_ok_pct = 100;
        push_item(mwe_pkg::KIND_TICK, 7'h7F, 16'hFFFF, 1'b1);
        push_item(mwe_pkg::KIND_TICK, 7'h00, 16'h0000, 1'b0);
        for (int k = KIND_ALIAS_LO; k <= KIND_ALIAS_HI; k++)
            push_item(3'(k), 7'($urandom), 16'($urandom), 1'($urandom));
        push_command(mwe_pkg::KIND_WRITE_EN);
        push_command(mwe_pkg::KIND_READ_ALL);
        push_item(mwe_pkg::KIND_WRITE_WORD, 7'h7F, 16'hFFFF, 1'b1);
        push_command(mwe_pkg::KIND_WRITE_DIS);
        tick_until_idle(0);
        push_command(mwe_pkg::KIND_WRITE_DIS);
        tick_until_idle(0);
        wait_all_done();

        // Zero word count, half period and wait, with a high ready level.
        set_config(8'd0, 8'd0, 24'd0, 1'b1);
        @(negedge aclk);
        push_command(mwe_pkg::KIND_READ_ALL);
        tick_until_idle(0);
        push_item(mwe_pkg::KIND_WRITE_WORD, 7'h7F, 16'hFFFF, 1'b0);
        tick_until_idle(0);
        // Wrong DO after both waits, then a high dummy bit.
        critical_ok_pct = 0;
        push_item(mwe_pkg::KIND_WRITE_WORD, 7'h00, 16'h0000, 1'b1);
        tick_until_idle(0);
        push_command(mwe_pkg::KIND_READ_ALL);
        tick_until_idle(0);
        wait_all_done();

        // A slower serial clock with a bare command.
        set_config(8'd1, 8'd4, 24'd12, 1'b1);
        @(negedge aclk);
        critical_ok_pct = 100;
        push_command(mwe_pkg::KIND_WRITE_DIS);
        tick_until_idle(0);
        wait_all_done();

        for (int mode = 0; mode < 3; mode++) begin
            @(negedge aclk);
            tx_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 60 : 0;
            rx_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 32 : 0;
            for (int part = 0; part < 3; part++) begin
                wait_all_done();
                set_config(8'($urandom_range(3, 1)), 8'($urandom_range(2, 1)),
                           24'($urandom_range(6, 1)), 1'($urandom_range(1)));
                critical_ok_pct = 85;
                if (mode == 2 && part == 0) begin
                    @(negedge aclk);
                    hold_at = items_pushed + 20;
                end
                if (mode == 2 && part == 1) begin
                    // Let the block run dry mid-stream before offering more items.
                    fill_random(PART_ITEMS / 2);
                    wait_all_done();
                    fill_random(PART_ITEMS / 2);
                end else begin
                    fill_random(PART_ITEMS);
                end
            end
        end

        wait_all_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        fail_total = mismatch_count + expected_results.size();
        $display("Checked %0d results from %0d items: %0d read-all, %0d write-word,",
                 results_checked, items_pushed, read_all_count, write_word_count);
        $display("%0d EWEN/EWDS, %0d refused, %0d words read; zero, small and slow settings.",
                 enable_count, refused_count, words_read);
        if (fail_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
